[hw/rtl/mlsk_pkg.sv]
package mlsk_pkg;

  // Register indexes on the configuration port, one 32-bit word each.
  localparam logic [2:0] REG_DIGIT_VALUES   = 3'd0;
  localparam logic [2:0] REG_DIGIT_MODES    = 3'd1;
  localparam logic [2:0] REG_AUX_ON_MASK    = 3'd2;
  localparam logic [2:0] REG_AUX_BLINK_MASK = 3'd3;
  localparam logic [2:0] REG_ALARM_LEVEL    = 3'd4;
  localparam logic [2:0] REG_BLINK_PERIOD   = 3'd5;
  localparam logic [2:0] REG_DEBOUNCE_TICKS = 3'd6;

  // Register values after reset.
  localparam logic [15:0] DIGIT_VALUES_RST   = 16'd0;
  localparam logic [7:0]  DIGIT_MODES_RST    = 8'h55;
  localparam logic [7:0]  AUX_ON_MASK_RST    = 8'd0;
  localparam logic [7:0]  AUX_BLINK_MASK_RST = 8'd0;
  localparam logic        ALARM_LEVEL_RST    = 1'b0;
  localparam logic [15:0] BLINK_PERIOD_RST   = 16'd500;
  localparam logic [15:0] DEBOUNCE_TICKS_RST = 16'd20;

  // Number of digits that the value and mode registers can describe.
  localparam int unsigned DIGIT_SLOTS = 4;

  // Digit mode codes.
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_BLINK = 2'd2;
  localparam logic [1:0] MODE_DARK  = 2'd3;

  // Configuration registers as seen by the display and key logic.
  typedef struct packed {
    logic [15:0] digit_values;
    logic [7:0]  digit_modes;
    logic [7:0]  aux_on_mask;
    logic [7:0]  aux_blink_mask;
    logic [15:0] blink_period;
    logic [15:0] debounce_ticks;
  } cfg_t;

  // One scan tick: whether it is taken this cycle and the position it selects.
  typedef struct packed {
    logic       adv;
    logic [3:0] pos;
  } tick_t;

  // Seven-segment code, segment A in bit 0 through G in bit 6.
  function automatic logic [7:0] seg_code(input logic [3:0] val);
    logic [7:0] code;
    case (val)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h49;
    endcase
    return code;
  endfunction

endpackage

[hw/rtl/mlsk_disp.sv]
module mlsk_disp
  import mlsk_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  tick_t      tick,
  input  cfg_t       cfg,
  output logic [7:0] seg
);

  logic        phase_r;
  logic        phase_nxt;
  logic [15:0] cd_r;
  logic [15:0] cd_nxt;
  logic [15:0] cd_dec;
  logic [3:0]  dval;
  logic [1:0]  mode;
  logic [7:0]  digit_seg;

  // Digit value and mode of the selected position.
  assign dval = 4'(cfg.digit_values >> {tick.pos[1:0], 2'b00});
  assign mode = 2'(cfg.digit_modes >> {tick.pos[1:0], 1'b0});

  always_comb begin
    case (mode)
      MODE_ON:    digit_seg = seg_code(dval);
      MODE_BLINK: digit_seg = phase_r ? seg_code(dval) : 8'd0;
      MODE_OFF:   digit_seg = 8'd0;
      MODE_DARK:  digit_seg = 8'd0;
      default:    digit_seg = 8'd0;
    endcase
  end

  // Segment drive uses the blink phase held at the start of the tick.
  always_comb begin
    if (tick.pos == 4'(NUM_DIGITS)) begin
      seg = phase_r ? cfg.aux_on_mask : (cfg.aux_on_mask & ~cfg.aux_blink_mask);
    end else if (tick.pos < 4'(DIGIT_SLOTS)) begin
      seg = digit_seg;
    end else begin
      seg = 8'd0;
    end
  end

  // Blink timer: count down, toggle the phase and reload when it runs out.
  always_comb begin
    cd_dec    = (cd_r != 16'd0) ? cd_r - 16'd1 : 16'd0;
    cd_nxt    = cd_dec;
    phase_nxt = phase_r;
    if (cd_dec == 16'd0) begin
      phase_nxt = ~phase_r;
      cd_nxt    = (cfg.blink_period != 16'd0) ? cfg.blink_period : 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      cd_r    <= BLINK_PERIOD_RST;
    end else if (tick.adv) begin
      phase_r <= phase_nxt;
      cd_r    <= cd_nxt;
    end
  end

  // The timer reloads before it can rest at zero.
  a_cd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cd_r != 16'd0)
    else $error("blink countdown reached zero");

endmodule

[hw/rtl/mlsk_keys.sv]
module mlsk_keys
  import mlsk_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tick_t       tick,
  input  logic        key_level,
  input  logic [15:0] debounce_ticks,
  output logic [4:0]  keys
);

  localparam int unsigned NUM_POS = NUM_DIGITS + 1;
  localparam int unsigned POS_W   = $clog2(NUM_POS);
  localparam int unsigned KEY_N   = (NUM_POS < 5) ? NUM_POS : 5;

  logic [POS_W-1:0]   p;
  logic               loaded;
  logic [NUM_POS-1:0] last_r;
  logic [NUM_POS-1:0] last_nxt;
  logic [NUM_POS-1:0] stable_r;
  logic [NUM_POS-1:0] stable_nxt;
  logic [15:0]        cd_r   [NUM_POS];
  logic [15:0]        cd_nxt [NUM_POS];

  assign p = tick.pos[POS_W-1:0];

  // Debounce update for the active position; all other countdowns run down.
  always_comb begin
    last_nxt   = last_r;
    stable_nxt = stable_r;
    loaded     = 1'b0;
    if (key_level != last_r[p]) begin
      last_nxt[p] = key_level;
      loaded      = 1'b1;
    end else if (cd_r[p] == 16'd0) begin
      stable_nxt[p] = key_level;
    end
    for (int i = 0; i < NUM_POS; i++) begin
      cd_nxt[i] = (cd_r[i] != 16'd0) ? cd_r[i] - 16'd1 : 16'd0;
    end
    if (loaded) begin
      cd_nxt[p] = debounce_ticks;
    end
  end

  // Debounced levels after this tick's update.
  always_comb begin
    keys = 5'd0;
    for (int i = 0; i < KEY_N; i++) begin
      keys[i] = stable_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      stable_r <= '0;
      for (int i = 0; i < NUM_POS; i++) begin
        cd_r[i] <= 16'd0;
      end
    end else if (tick.adv) begin
      last_r   <= last_nxt;
      stable_r <= stable_nxt;
      for (int i = 0; i < NUM_POS; i++) begin
        cd_r[i] <= cd_nxt[i];
      end
    end
  end

endmodule

[hw/rtl/multiplexed_led_scan_with_key_debounce_top.sv]
// Multiplexed seven-segment display scanner with per-position key debounce.
// Each input transaction is one scan tick carrying the sensed key level; it
// advances the scan over NUM_DIGITS digits plus one extra LED row and yields
// one output transaction with the selected position, its segment drive, the
// alarm level and the debounced keys. A tick is taken every clock cycle while
// the input is not stalled: it passes through an input register, one level of
// decode and update logic, and an output register that presents the result.
// Stalls on the output back up into the input only when both registers are
// full. Registers sit at byte addresses 4*i on the APB port and must be
// written only while no tick is in flight.
module multiplexed_led_scan_with_key_debounce_top
  import mlsk_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_key_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_position_select,
  output logic [7:0]  out_segment_lines,
  output logic        out_alarm_out,
  output logic [4:0]  out_debounced_keys,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NUM_POS = NUM_DIGITS + 1;
  localparam int unsigned POS_W   = $clog2(NUM_POS);

  cfg_t             cfg_r;
  logic             alarm_r;
  logic [2:0]       reg_idx;
  logic             cfg_wr;

  logic             s1_valid_r;
  logic             s1_key_r;
  logic             adv;
  logic [POS_W-1:0] scan_pos_r;
  logic [POS_W-1:0] scan_pos_nxt;
  tick_t            tick;
  logic [7:0]       seg;
  logic [4:0]       keys;

  logic             out_valid_r;
  logic [2:0]       out_pos_r;
  logic [7:0]       out_seg_r;
  logic             out_alarm_r;
  logic [4:0]       out_keys_r;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.digit_values   <= DIGIT_VALUES_RST;
      cfg_r.digit_modes    <= DIGIT_MODES_RST;
      cfg_r.aux_on_mask    <= AUX_ON_MASK_RST;
      cfg_r.aux_blink_mask <= AUX_BLINK_MASK_RST;
      cfg_r.blink_period   <= BLINK_PERIOD_RST;
      cfg_r.debounce_ticks <= DEBOUNCE_TICKS_RST;
      alarm_r              <= ALARM_LEVEL_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DIGIT_VALUES:   cfg_r.digit_values   <= pwdata[15:0];
        REG_DIGIT_MODES:    cfg_r.digit_modes    <= pwdata[7:0];
        REG_AUX_ON_MASK:    cfg_r.aux_on_mask    <= pwdata[7:0];
        REG_AUX_BLINK_MASK: cfg_r.aux_blink_mask <= pwdata[7:0];
        REG_ALARM_LEVEL:    alarm_r              <= pwdata[0];
        REG_BLINK_PERIOD:   cfg_r.blink_period   <= pwdata[15:0];
        REG_DEBOUNCE_TICKS: cfg_r.debounce_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIGIT_VALUES:   prdata = 32'(cfg_r.digit_values);
      REG_DIGIT_MODES:    prdata = 32'(cfg_r.digit_modes);
      REG_AUX_ON_MASK:    prdata = 32'(cfg_r.aux_on_mask);
      REG_AUX_BLINK_MASK: prdata = 32'(cfg_r.aux_blink_mask);
      REG_ALARM_LEVEL:    prdata = 32'(alarm_r);
      REG_BLINK_PERIOD:   prdata = 32'(cfg_r.blink_period);
      REG_DEBOUNCE_TICKS: prdata = 32'(cfg_r.debounce_ticks);
      default:            prdata = 32'd0;
    endcase
  end

  // A tick moves from the input register when the output register frees up.
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_key_r <= in_key_level;
    end
  end

  // Scan position advances first, wrapping after the extra row.
  assign scan_pos_nxt = (scan_pos_r == POS_W'(NUM_POS - 1)) ? '0 : scan_pos_r + POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_pos_r <= '0;
    end else if (adv) begin
      scan_pos_r <= scan_pos_nxt;
    end
  end

  assign tick.adv = adv;
  assign tick.pos = 4'(scan_pos_nxt);

  mlsk_disp #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_disp (
    .clk   (clk),
    .rst_n (rst_n),
    .tick  (tick),
    .cfg   (cfg_r),
    .seg   (seg)
  );

  mlsk_keys #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_keys (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick           (tick),
    .key_level      (s1_key_r),
    .debounce_ticks (cfg_r.debounce_ticks),
    .keys           (keys)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pos_r   <= 3'(scan_pos_nxt);
      out_seg_r   <= seg;
      out_alarm_r <= alarm_r;
      out_keys_r  <= keys;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_position_select = out_pos_r;
  assign out_segment_lines   = out_seg_r;
  assign out_alarm_out       = out_alarm_r;
  assign out_debounced_keys  = out_keys_r;

  // A tick that leaves the input register always lands in the output register.
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced tick did not reach the output register");

  // The input side stalls only behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a held result");

  // The scan position stays within the digits and the extra row.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    4'(scan_pos_r) < 4'(NUM_POS))
    else $error("scan position out of range");

endmodule
